// ----- src/mat3_determinant_inverse_defines.svh -----
// Assertion macros shared by the 3x3 inverse RTL.
// No dependencies; included by the top module, mat3_determinant_inverse.
`ifndef MAT3_DETERMINANT_INVERSE_DEFINES_SVH
`define MAT3_DETERMINANT_INVERSE_DEFINES_SVH
`ifndef SYNTH
`define M3DI_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define M3DI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define M3DI_ASSERT_IMPLY(lbl, ante, cons)
`define M3DI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- src/mat3di_pkg.sv -----
// Shared constants for the 3x3 determinant and inverse pipeline.
// No dependencies.
package mat3di_pkg;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_ELEM_WIDTH = 32;
    localparam int NUM_ENTRIES    = 9;
endpackage

// ----- src/mat3di_if.sv -----
// Valid/ready channel interfaces for matrix requests and results.
// Depends on mat3di_pkg for default widths.
interface mat3di_in_if import mat3di_pkg::*; #(parameter int W = DEF_ELEM_WIDTH);
    logic valid;
    logic ready;
    logic signed [W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    input ready);
    modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

interface mat3di_out_if import mat3di_pkg::*; #(parameter int W = DEF_ELEM_WIDTH);
    logic valid;
    logic ready;
    logic signed [W-1:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
    logic signed [W-1:0] determinant;
    logic singular;
    modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20,
                    inv21, inv22, determinant, singular, input ready);
    modport sink (input valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20,
                  inv21, inv22, determinant, singular, output ready);
endinterface

// ----- src/mat3di_cofactor.sv -----
// Two-stage cofactor unit: 2x2 minor products, then rounded saturated cofactors.
// Depends on mat3di_pkg.
module mat3di_cofactor import mat3di_pkg::*; #(
    parameter int W = DEF_ELEM_WIDTH,
    parameter int F = DEF_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ce,
    input  logic                in_valid,
    input  logic signed [W-1:0] a [NUM_ENTRIES],
    output logic signed [W-1:0] cof [NUM_ENTRIES],
    output logic signed [W-1:0] row0 [3],
    output logic                out_valid
);
    localparam int PW = 2 * W;
    localparam int MW = 2 * W + 1;
    localparam logic [MW-1:0] HALF = {{(MW-1){1'b0}}, 1'b1} << (F - 1);
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic                v1_reg, v2_reg;
    logic signed [W-1:0] row0a_reg [3];
    logic signed [W-1:0] row0b_reg [3];
    logic signed [W-1:0] cof_reg [NUM_ENTRIES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int c = 0; c < 3; c++)
            begin
                row0a_reg[c] <= a[c];
                row0b_reg[c] <= row0a_reg[c];
            end
        end
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            localparam int R1 = (r == 0) ? 1 : 0;
            localparam int R2 = (r == 2) ? 1 : 2;
            localparam int C1 = (c == 0) ? 1 : 0;
            localparam int C2 = (c == 2) ? 1 : 2;
            logic signed [PW-1:0] pa_reg, pb_reg;
            logic signed [MW-1:0] m, mn, sh;
            logic [MW-W:0]        top;
            logic                 ovf;

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    pa_reg <= a[R1*3+C1] * a[R2*3+C2];
                    pb_reg <= a[R1*3+C2] * a[R2*3+C1];
                end
            end

            // Odd positions of the checkerboard take the negated minor.
            assign m   = {pa_reg[PW-1], pa_reg} - {pb_reg[PW-1], pb_reg};
            assign mn  = ((r + c) % 2 == 1) ? -m : m;
            assign sh  = (mn + $signed(HALF)) >>> F;
            assign top = sh[MW-1:W-1];
            assign ovf = (|top) && !(&top);

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    cof_reg[r*3+c] <= ovf ? (sh[MW-1] ? MINV : MAXV) : sh[W-1:0];
                end
            end
        end
    end

    assign cof       = cof_reg;
    assign row0      = row0b_reg;
    assign out_valid = v2_reg;
endmodule

// ----- src/mat3di_det.sv -----
// Two-stage determinant unit: row 0 times its cofactors, then rounded saturated sum.
// Depends on mat3di_pkg.
module mat3di_det import mat3di_pkg::*; #(
    parameter int W = DEF_ELEM_WIDTH,
    parameter int F = DEF_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ce,
    input  logic                in_valid,
    input  logic signed [W-1:0] cof_in [NUM_ENTRIES],
    input  logic signed [W-1:0] row0 [3],
    output logic signed [W-1:0] cof_out [NUM_ENTRIES],
    output logic signed [W-1:0] det,
    output logic                out_valid
);
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;
    localparam logic [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (F - 1);
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic                 v1_reg, v2_reg;
    logic signed [PW-1:0] dp_reg [3];
    logic signed [W-1:0]  cofa_reg [NUM_ENTRIES];
    logic signed [W-1:0]  cofb_reg [NUM_ENTRIES];
    logic signed [W-1:0]  det_reg;
    logic signed [SW-1:0] sum, sh;
    logic [SW-W:0]        top;
    logic                 ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign sum = $signed({{2{dp_reg[0][PW-1]}}, dp_reg[0]})
               + $signed({{2{dp_reg[1][PW-1]}}, dp_reg[1]})
               + $signed({{2{dp_reg[2][PW-1]}}, dp_reg[2]})
               + $signed(HALF);
    assign sh  = sum >>> F;
    assign top = sh[SW-1:W-1];
    assign ovf = (|top) && !(&top);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int c = 0; c < 3; c++)
            begin
                dp_reg[c] <= row0[c] * cof_in[c];
            end
            cofa_reg <= cof_in;
            cofb_reg <= cofa_reg;
            det_reg  <= ovf ? (sh[SW-1] ? MINV : MAXV) : sh[W-1:0];
        end
    end

    assign cof_out   = cofb_reg;
    assign det       = det_reg;
    assign out_valid = v2_reg;
endmodule

// ----- src/mat3di_divider.sv -----
// Nine-lane restoring divider, one quotient bit per stage, with rounding and saturation.
// Depends on mat3di_pkg.
module mat3di_divider import mat3di_pkg::*; #(
    parameter int W = DEF_ELEM_WIDTH,
    parameter int F = DEF_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ce,
    input  logic                in_valid,
    input  logic signed [W-1:0] cof [NUM_ENTRIES],
    input  logic signed [W-1:0] det_in,
    output logic signed [W-1:0] inv [NUM_ENTRIES],
    output logic signed [W-1:0] det_out,
    output logic                singular,
    output logic                out_valid
);
    localparam int NB = W + F;
    localparam int QW = NB + 2;
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]        rem_reg  [NB+1][NUM_ENTRIES];
    logic [NB-1:0]       nq_reg   [NB+1][NUM_ENTRIES];
    logic                neg_reg  [NB+1][NUM_ENTRIES];
    logic [W-1:0]        d_reg    [NB+1];
    logic                sing_reg [NB+1];
    logic signed [W-1:0] det_reg  [NB+1];
    logic                vld_reg  [NB+1];
    logic signed [W-1:0] inv_reg  [NUM_ENTRIES];
    logic signed [W-1:0] deto_reg;
    logic                singo_reg, vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NB; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            vo_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= NB; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            vo_reg <= vld_reg[NB];
        end
    end

    // Load stage: magnitudes, signs and the singular flag.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            d_reg[0]    <= det_in[W-1] ? W'(-det_in) : det_in;
            sing_reg[0] <= (det_in == '0);
            det_reg[0]  <= det_in;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    rem_reg[0][i*3+j] <= '0;
                    nq_reg[0][i*3+j]  <= {(cof[j*3+i][W-1] ? W'(-cof[j*3+i]) : cof[j*3+i]),
                                          {F{1'b0}}};
                    neg_reg[0][i*3+j] <= cof[j*3+i][W-1] ^ det_in[W-1];
                end
            end
        end
    end

    for (genvar k = 1; k <= NB; k++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                d_reg[k]    <= d_reg[k-1];
                sing_reg[k] <= sing_reg[k-1];
                det_reg[k]  <= det_reg[k-1];
            end
        end

        for (genvar l = 0; l < NUM_ENTRIES; l++)
        begin : g_lane
            logic [W:0] t;
            logic       ge;

            assign t  = {rem_reg[k-1][l], nq_reg[k-1][l][NB-1]};
            assign ge = (t >= {1'b0, d_reg[k-1]});

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    rem_reg[k][l] <= ge ? W'(t - {1'b0, d_reg[k-1]}) : t[W-1:0];
                    nq_reg[k][l]  <= {nq_reg[k-1][l][NB-2:0], ge};
                    neg_reg[k][l] <= neg_reg[k-1][l];
                end
            end
        end
    end

    // Final stage: round half away from zero, apply sign, saturate; a singular matrix gives zero.
    for (genvar l = 0; l < NUM_ENTRIES; l++)
    begin : g_out
        logic          up;
        logic [NB:0]   qr;
        logic [QW-1:0] sv;
        logic [QW-W:0] top;
        logic          ovf;

        assign up  = ({rem_reg[NB][l], 1'b0} >= {1'b0, d_reg[NB]});
        assign qr  = {1'b0, nq_reg[NB][l]} + {{NB{1'b0}}, up};
        assign sv  = neg_reg[NB][l] ? -{1'b0, qr} : {1'b0, qr};
        assign top = sv[QW-1:W-1];
        assign ovf = (|top) && !(&top);

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                if (sing_reg[NB])
                    inv_reg[l] <= '0;
                else
                    inv_reg[l] <= ovf ? (sv[QW-1] ? MINV : MAXV) : sv[W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            deto_reg  <= det_reg[NB];
            singo_reg <= sing_reg[NB];
        end
    end

    assign inv       = inv_reg;
    assign det_out   = deto_reg;
    assign singular  = singo_reg;
    assign out_valid = vo_reg;
endmodule

// ----- src/mat3_determinant_inverse.sv -----
// 3x3 inverse by the adjugate, computed by cofactor, determinant and divider stages;
// the divider resolves one quotient bit per register stage.
// Throughput is one request per cycle; the whole pipeline holds while a result waits.
// Reset (rst_n, asynchronous, active low) clears every valid bit; data registers
// are not reset. There is no state between requests.
`include "mat3_determinant_inverse_defines.svh"
module mat3_determinant_inverse import mat3di_pkg::*; #(
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input logic       clk,
    input logic       rst_n,
    mat3di_in_if.sink   matrix,
    mat3di_out_if.source result
);
    localparam int W = ELEM_WIDTH;

    logic                ce;
    logic signed [W-1:0] a [NUM_ENTRIES];
    logic signed [W-1:0] cof1 [NUM_ENTRIES];
    logic signed [W-1:0] cof2 [NUM_ENTRIES];
    logic signed [W-1:0] row0 [3];
    logic signed [W-1:0] det;
    logic signed [W-1:0] inv [NUM_ENTRIES];
    logic signed [W-1:0] det_out;
    logic                v_cof, v_det, v_out, sing;

    // Every stage moves together; the pipeline only stops when the output
    // register holds a result that the sink has not taken yet.
    assign ce           = !v_out || result.ready;
    assign matrix.ready = ce;

    assign a[0] = matrix.a00;
    assign a[1] = matrix.a01;
    assign a[2] = matrix.a02;
    assign a[3] = matrix.a10;
    assign a[4] = matrix.a11;
    assign a[5] = matrix.a12;
    assign a[6] = matrix.a20;
    assign a[7] = matrix.a21;
    assign a[8] = matrix.a22;

    // Stages 1-2: minor products, then rounded cofactors.
    mat3di_cofactor #(.W(W), .F(FRAC_BITS)) u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (matrix.valid),
        .a         (a),
        .cof       (cof1),
        .row0      (row0),
        .out_valid (v_cof)
    );

    // Stages 3-4: expansion along row 0.
    mat3di_det #(.W(W), .F(FRAC_BITS)) u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v_cof),
        .cof_in    (cof1),
        .row0      (row0),
        .cof_out   (cof2),
        .det       (det),
        .out_valid (v_det)
    );

    // Remaining stages: nine parallel bit-per-stage dividers and the output register.
    mat3di_divider #(.W(W), .F(FRAC_BITS)) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v_det),
        .cof       (cof2),
        .det_in    (det),
        .inv       (inv),
        .det_out   (det_out),
        .singular  (sing),
        .out_valid (v_out)
    );

    assign result.valid       = v_out;
    assign result.inv00       = inv[0];
    assign result.inv01       = inv[1];
    assign result.inv02       = inv[2];
    assign result.inv10       = inv[3];
    assign result.inv11       = inv[4];
    assign result.inv12       = inv[5];
    assign result.inv20       = inv[6];
    assign result.inv21       = inv[7];
    assign result.inv22       = inv[8];
    assign result.determinant = det_out;
    assign result.singular    = sing;

    // A singular result carries a zero determinant and a zero inverse.
    `M3DI_ASSERT_IMPLY(a_sing_zero, v_out && sing, det_out == '0 && inv[0] == '0 && inv[4] == '0 && inv[8] == '0)
    // A regular result never carries a zero determinant.
    `M3DI_ASSERT_IMPLY(a_reg_nonzero, v_out && !sing, det_out != '0)
    // With the output register empty, a new request is always taken.
    `M3DI_ASSERT_IMPLY(a_ready_empty, !v_out, matrix.ready)
    // A held result keeps its determinant while the pipeline stalls.
    `M3DI_ASSERT_NEXT(a_hold_det, v_out && !result.ready, det_out == $past(det_out))
endmodule
